// ===== hdl/ic3_pkg.sv =====
// ---------------------------------------------------------------------------
// ic3_pkg: shared types and constants of the 3x3 convolution core
// Pixel and coefficient formats, register indexes, opcodes and the control
// bundles that pass between the core and its window cells.
// ---------------------------------------------------------------------------
`default_nettype none

package ic3_pkg;

  // kernel geometry and number formats
  localparam int unsigned KERNEL_SIZE = 3;
  localparam int unsigned PIX_W       = 8;
  localparam int unsigned COEF_W      = 20;
  localparam int unsigned FRAC_BITS   = 12;
  localparam int unsigned KROW_W      = KERNEL_SIZE * COEF_W;
  localparam int unsigned PROD_W      = 28;
  localparam int unsigned SUM_W       = 32;
  localparam int unsigned DIM_CFG_W   = 11;

  // configuration port
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = KROW_W;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_TOP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_MIDDLE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_BOTTOM = 3'd4;

  // input opcodes
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // one window column: index 0 is the oldest row, 2 the current row
  typedef logic [KERNEL_SIZE-1:0][PIX_W-1:0]  pix_col_t;
  typedef logic [KERNEL_SIZE-1:0][COEF_W-1:0] coef_col_t;
  typedef logic [KERNEL_SIZE-1:0][PROD_W-1:0] prod_col_t;
  typedef logic [KERNEL_SIZE-1:0][KROW_W-1:0] kernel_t;

  // per-beat sideband carried down the pipeline
  typedef struct packed {
    logic prod;        // beat yields a result
    logic eor;
    logic eof;
    logic first;       // first beat of a frame, window starts empty
    logic keep_top;    // row above the output pixel is inside the image
    logic keep_bot;    // row below the output pixel is inside the image
    logic keep_left;
    logic keep_right;
  } sband_t;

  // control into one window cell
  typedef struct packed {
    logic shift;       // take the neighbour's column
    logic zero_fill;   // load an empty column instead
    logic advance;     // pipeline moves this cycle
    logic keep_top;
    logic keep_bot;
    logic keep_col;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/image_convolution_3x3_core.sv =====
// ---------------------------------------------------------------------------
// image_convolution_3x3_core: zero-padded 3x3 convolution of a pixel stream
// Line buffer, a chain of three window column cells, an adder tree and
// round-to-even saturation to 8 bits.
// ---------------------------------------------------------------------------
// Usage
//   Input channel: in_valid_i/in_stall_o with opcode_i and in_pixel_i, pixels
//   in raster order. A flush beat drains results once the last pixel of the
//   frame is in; a flush before then is taken and dropped, a pixel after it
//   is treated as a flush.
//   Output channel: out_valid_o/out_stall_i with out_pixel_o, end_of_row_o,
//   end_of_frame_o. Result (r,c) is produced by the beat that carries pixel
//   (r+1,c+1) in stream order, i.e. one row plus one pixel behind.
//   Configuration: cfg_valid_i/cfg_ready_o, always ready. Writing the width
//   or height restarts the frame; write only while the core is idle.
//   Throughput: one beat per clock while the output is not stalled. A result
//   reaches the output register through the line buffer read, window
//   shift, multiply, two adder levels and the rounding stage.
//   Stall: the whole pipeline holds while a result waits and out_stall_i is
//   high; in_stall_o then rises in the same cycle.
//   Reset: counters and window clear, width and height go to 1024 (clamped
//   to the maximum), coefficients to zero. The line store needs no clear.
// ---------------------------------------------------------------------------
`default_nettype none

module image_convolution_3x3_core #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [ic3_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [ic3_pkg::CFG_DAT_W-1:0] cfg_data_i,
  // input pixels
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          opcode_i,
  input  wire logic [ic3_pkg::PIX_W-1:0]     in_pixel_i,
  // results
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [ic3_pkg::PIX_W-1:0]          out_pixel_o,
  output logic                               end_of_row_o,
  output logic                               end_of_frame_o
);
  import ic3_pkg::*;

  localparam int unsigned WW  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CIW = $clog2(MAX_WIDTH);
  localparam int unsigned HW  = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned RIW = $clog2(MAX_HEIGHT);
  localparam int unsigned RW  = $clog2(MAX_HEIGHT + 2);
  localparam int unsigned W_RESET = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
  localparam int unsigned H_RESET = (MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024;
  localparam int unsigned F_W = SUM_W - FRAC_BITS;

  // configuration registers
  logic [WW-1:0] w_q;
  logic [HW-1:0] h_q;
  kernel_t       kern_q;
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic          cfg_we;
  logic          geo_we;
  logic [DIM_CFG_W-1:0] dim_raw;

  // frame counters
  logic [CIW-1:0] ci_q;
  logic [RW-1:0]  ri_q;
  logic [CIW-1:0] co_q;
  logic [RIW-1:0] ro_q;

  // pipeline control
  logic   adv;
  logic   accept;
  logic   take;
  logic   row_in_frame;
  logic   ci_last;
  logic [PIX_W-1:0] px0;
  sband_t sb0;
  logic   v1_q, v2_q, v3_q, v4_q, v5_q, out_valid_q;
  sband_t sb1_q, sb2_q, sb3_q, sb4_q, sb5_q;
  logic   eor_q, eof_q;

  // datapath
  pix_col_t   lb_col;
  pix_col_t   cell_in  [KERNEL_SIZE];
  pix_col_t   cell_out [KERNEL_SIZE];
  coef_col_t  cell_coef [KERNEL_SIZE];
  prod_col_t  cell_prod [KERNEL_SIZE];
  cell_ctrl_t cell_ctrl [KERNEL_SIZE];
  logic signed [SUM_W-1:0] colsum_q [KERNEL_SIZE];
  logic signed [SUM_W-1:0] total_q;
  logic [PIX_W-1:0]        pix_d;
  logic [PIX_W-1:0]        pix_q;

  // handshakes
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i;
  assign adv         = !out_valid_q || !out_stall_i;
  assign in_stall_o  = !adv;
  assign accept      = in_valid_i && adv;

  // clamp the geometry to 1..max
  assign dim_raw = cfg_data_i[DIM_CFG_W-1:0];
  always_comb begin
    if (dim_raw == '0) begin
      w_eff = WW'(1);
      h_eff = HW'(1);
    end else begin
      w_eff = (int'(dim_raw) > MAX_WIDTH)  ? WW'(MAX_WIDTH)  : WW'(dim_raw);
      h_eff = (int'(dim_raw) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(dim_raw);
    end
  end

  assign geo_we = cfg_we &&
                  (cfg_index_i == CFG_IMAGE_WIDTH || cfg_index_i == CFG_IMAGE_HEIGHT);

  // register decode
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q    <= WW'(W_RESET);
      h_q    <= HW'(H_RESET);
      kern_q <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        CFG_IMAGE_WIDTH:   w_q       <= w_eff;
        CFG_IMAGE_HEIGHT:  h_q       <= h_eff;
        CFG_KERNEL_TOP:    kern_q[0] <= cfg_data_i;
        CFG_KERNEL_MIDDLE: kern_q[1] <= cfg_data_i;
        CFG_KERNEL_BOTTOM: kern_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // beat classification at the input
  assign row_in_frame = ri_q < RW'(h_q);
  assign take         = accept && !(row_in_frame && opcode_i == OP_FLUSH);
  assign px0          = row_in_frame ? in_pixel_i : '0;
  assign ci_last      = (WW'(ci_q) + WW'(1)) == w_q;

  always_comb begin
    sb0.prod       = (ri_q >= RW'(2)) || (ri_q == RW'(1) && ci_q != '0);
    sb0.eor        = (WW'(co_q) + WW'(1)) == w_q;
    sb0.eof        = sb0.eor && ((HW'(ro_q) + HW'(1)) == h_q);
    sb0.first      = (ri_q == '0) && (ci_q == '0);
    sb0.keep_top   = ro_q != '0;
    sb0.keep_bot   = (HW'(ro_q) + HW'(1)) != h_q;
    sb0.keep_left  = co_q != '0;
    sb0.keep_right = !sb0.eor;
  end

  // input and output position counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ci_q <= '0;
      ri_q <= '0;
      co_q <= '0;
      ro_q <= '0;
    end else if (geo_we) begin
      ci_q <= '0;
      ri_q <= '0;
      co_q <= '0;
      ro_q <= '0;
    end else if (take) begin
      if (sb0.prod && sb0.eof) begin
        ci_q <= '0;
        ri_q <= '0;
        co_q <= '0;
        ro_q <= '0;
      end else begin
        if (ci_last) begin
          ci_q <= '0;
          ri_q <= ri_q + RW'(1);
        end else begin
          ci_q <= ci_q + CIW'(1);
        end
        if (sb0.prod) begin
          if (sb0.eor) begin
            co_q <= '0;
            ro_q <= ro_q + RIW'(1);
          end else begin
            co_q <= co_q + CIW'(1);
          end
        end
      end
    end
  end

  // line buffer
  ic3_line_buf #(
    .Depth(MAX_WIDTH)
  ) u_line_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (take),
    .rd_addr_i  (ci_q),
    .rd_pixel_i (px0),
    .rd_mid_ok_i(ri_q >= RW'(1)),
    .rd_top_ok_i(ri_q >= RW'(2)),
    .wr_en_i    (adv && v1_q),
    .col_o      (lb_col)
  );

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v1_q        <= take;
      v2_q        <= v1_q;
      v3_q        <= v2_q && sb2_q.prod;
      v4_q        <= v3_q;
      v5_q        <= v4_q;
      out_valid_q <= v5_q;
    end
  end

  // stage sideband
  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (take) begin
        sb1_q <= sb0;
      end
      sb2_q <= sb1_q;
      sb3_q <= sb2_q;
      sb4_q <= sb3_q;
      sb5_q <= sb4_q;
      eor_q <= sb5_q.eor;
      eof_q <= sb5_q.eof;
    end
  end

  // chain of window cells, cell 2 holds the newest column
  for (genvar b = 0; b < KERNEL_SIZE; b++) begin : g_cell
    for (genvar a = 0; a < KERNEL_SIZE; a++) begin : g_coef
      assign cell_coef[b][a] =
        kern_q[KERNEL_SIZE-1-a][COEF_W*(KERNEL_SIZE-1-b) +: COEF_W];
    end

    if (b == KERNEL_SIZE - 1) begin : g_head
      assign cell_in[b]            = lb_col;
      assign cell_ctrl[b].zero_fill = 1'b0;
      assign cell_ctrl[b].keep_col  = sb2_q.keep_right;
    end else begin : g_body
      assign cell_in[b]            = cell_out[b+1];
      assign cell_ctrl[b].zero_fill = sb1_q.first;
      assign cell_ctrl[b].keep_col  = (b == 0) ? sb2_q.keep_left : 1'b1;
    end
    assign cell_ctrl[b].shift    = adv && v1_q;
    assign cell_ctrl[b].advance  = adv;
    assign cell_ctrl[b].keep_top = sb2_q.keep_top;
    assign cell_ctrl[b].keep_bot = sb2_q.keep_bot;

    ic3_col_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .ctrl_i(cell_ctrl[b]),
      .col_i (cell_in[b]),
      .coef_i(cell_coef[b]),
      .col_o (cell_out[b]),
      .prod_o(cell_prod[b])
    );
  end

  // adder tree: column sums, then the total
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int b = 0; b < KERNEL_SIZE; b++) begin
        colsum_q[b] <= SUM_W'($signed(cell_prod[b][0]))
                     + SUM_W'($signed(cell_prod[b][1]))
                     + SUM_W'($signed(cell_prod[b][2]));
      end
      total_q <= colsum_q[0] + colsum_q[1] + colsum_q[2];
    end
  end

  // round half to even, then clamp to 0..255
  always_comb begin
    logic signed [F_W-1:0]   floor_v;
    logic [FRAC_BITS-1:0]    frac;
    logic                    up;
    logic signed [F_W:0]     rnd;
    floor_v = total_q[SUM_W-1:FRAC_BITS];
    frac    = total_q[FRAC_BITS-1:0];
    up      = (frac > {1'b1, {(FRAC_BITS-1){1'b0}}}) ||
              (frac == {1'b1, {(FRAC_BITS-1){1'b0}}} && floor_v[0]);
    rnd     = {floor_v[F_W-1], floor_v} + $signed({{F_W{1'b0}}, up});
    if (rnd < 0) begin
      pix_d = '0;
    end else if (rnd > $signed((F_W+1)'(255))) begin
      pix_d = '1;
    end else begin
      pix_d = rnd[PIX_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pix_q <= pix_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_pixel_o    = pix_q;
  assign end_of_row_o   = eor_q;
  assign end_of_frame_o = eof_q;

`ifndef NO_ASSERTIONS
  // last pixel of the frame is also last of its row
  a_eof_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!end_of_frame_o || end_of_row_o))
    else $error("end of frame without end of row");

  // input column never reaches the row width
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    WW'(ci_q) < w_q)
    else $error("input column out of range");

  // draining never runs past two rows beyond the frame
  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ri_q <= (RW'(h_q) + RW'(1)))
    else $error("input row out of range");

  // the end-of-frame beat restarts the counters
  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && sb0.prod && sb0.eof) |=> (ri_q == '0 && ci_q == '0 && ro_q == '0))
    else $error("counters not restarted after end of frame");
`endif

endmodule

`default_nettype wire

// ===== hdl/ic3_line_buf.sv =====
// ---------------------------------------------------------------------------
// ic3_line_buf: two-row line buffer
// Holds the previous row and the row before it, one entry per column. A read
// captures the column, which is written back when the pipeline next advances,
// with a bypass for back-to-back hits on the same column (single-pixel rows).
// ---------------------------------------------------------------------------
`default_nettype none

module ic3_line_buf #(
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     rd_en_i,
  input  wire logic [AddrW-1:0]         rd_addr_i,
  input  wire logic [ic3_pkg::PIX_W-1:0] rd_pixel_i,
  input  wire logic                     rd_mid_ok_i,
  input  wire logic                     rd_top_ok_i,
  input  wire logic                     wr_en_i,
  output ic3_pkg::pix_col_t             col_o
);
  import ic3_pkg::*;

  logic [PIX_W-1:0] mem_prev  [Depth];
  logic [PIX_W-1:0] mem_prev2 [Depth];

  logic [AddrW-1:0] addr_q;
  logic [PIX_W-1:0] px_q;
  logic             mid_ok_q;
  logic             top_ok_q;
  logic [PIX_W-1:0] rd_prev_q;
  logic [PIX_W-1:0] rd_prev2_q;
  logic             byp_q;
  logic [PIX_W-1:0] byp_prev_q;
  logic [PIX_W-1:0] byp_prev2_q;
  logic [PIX_W-1:0] mid;
  logic [PIX_W-1:0] top;

  // column seen by the held beat, rows outside the frame read as zero
  always_comb begin
    mid = '0;
    top = '0;
    if (mid_ok_q) begin
      mid = byp_q ? byp_prev_q : rd_prev_q;
    end
    if (top_ok_q) begin
      top = byp_q ? byp_prev2_q : rd_prev2_q;
    end
  end

  assign col_o[0] = top;
  assign col_o[1] = mid;
  assign col_o[2] = px_q;

  // previous row store
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_prev[addr_q] <= px_q;
    end
    if (rd_en_i) begin
      rd_prev_q <= mem_prev[rd_addr_i];
    end
  end

  // row-before-previous store, fed from the previous row
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_prev2[addr_q] <= mid;
    end
    if (rd_en_i) begin
      rd_prev2_q <= mem_prev2[rd_addr_i];
    end
  end

  // request capture and bypass data
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      addr_q      <= rd_addr_i;
      px_q        <= rd_pixel_i;
      mid_ok_q    <= rd_mid_ok_i;
      top_ok_q    <= rd_top_ok_i;
      byp_prev_q  <= px_q;
      byp_prev2_q <= mid;
    end
  end

  // bypass flag when the write lands on the column being read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else if (rd_en_i) begin
      byp_q <= wr_en_i && (rd_addr_i == addr_q);
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ic3_col_cell.sv =====
// ---------------------------------------------------------------------------
// ic3_col_cell: one column of the 3x3 window
// Holds three pixels, passes them to the neighbouring cell on each shift and
// registers the three coefficient products of its column.
// ---------------------------------------------------------------------------
`default_nettype none

module ic3_col_cell (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  ic3_pkg::cell_ctrl_t     ctrl_i,
  input  ic3_pkg::pix_col_t       col_i,
  input  ic3_pkg::coef_col_t      coef_i,
  output ic3_pkg::pix_col_t       col_o,
  output ic3_pkg::prod_col_t      prod_o
);
  import ic3_pkg::*;

  pix_col_t  col_q;
  prod_col_t prod_q;
  prod_col_t prod_d;

  // window column
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else if (ctrl_i.shift) begin
      col_q <= ctrl_i.zero_fill ? '0 : col_i;
    end
  end

  // products, taps outside the image contribute nothing
  always_comb begin
    logic signed [COEF_W+PIX_W:0] full [KERNEL_SIZE];
    logic                         keep [KERNEL_SIZE];
    keep[0] = ctrl_i.keep_top;
    keep[1] = 1'b1;
    keep[2] = ctrl_i.keep_bot;
    for (int a = 0; a < KERNEL_SIZE; a++) begin
      full[a]   = $signed(coef_i[a]) * $signed({1'b0, col_q[a]});
      prod_d[a] = (keep[a] && ctrl_i.keep_col) ? full[a][PROD_W-1:0] : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.advance) begin
      prod_q <= prod_d;
    end
  end

  assign col_o  = col_q;
  assign prod_o = prod_q;

endmodule

`default_nettype wire
